### hw/rtl/ps2mct_pkg.sv
// ============================================================================
// ps2mct_pkg
// Shared types, codes and helpers for the PS/2 mouse cursor tracker.
// ============================================================================
package ps2mct_pkg;

   // Cursor coordinate width
   localparam int POS_BITS  = 12;
   // Signed width that holds a cursor value plus or minus one scaled move
   localparam int SUM_BITS  = POS_BITS + 2;
   // Signed width of a scaled move (-32 .. 31)
   localparam int MOVE_BITS = 7;
   // Signed width of a raw 9-bit motion value plus rounding headroom
   localparam int RAW_BITS  = 10;
   // Right shift that divides a motion value by 8
   localparam int MOVE_SHIFT = 3;

   localparam int BTN_BITS  = 3;
   localparam int CSR_BITS  = 2;

   // Bit positions in the first byte of a packet
   localparam int FLAG_SYNC   = 3;
   localparam int FLAG_X_SIGN = 4;
   localparam int FLAG_Y_SIGN = 5;
   localparam int FLAG_X_OVF  = 6;
   localparam int FLAG_Y_OVF  = 7;

   // Byte position within a packet
   localparam logic [1:0] BYTE_FIRST  = 2'd0;
   localparam logic [1:0] BYTE_SECOND = 2'd1;
   localparam logic [1:0] BYTE_THIRD  = 2'd2;

   // Bound reset values
   localparam logic [POS_BITS-1:0] LEFT_RESET   = POS_BITS'(0);
   localparam logic [POS_BITS-1:0] TOP_RESET    = POS_BITS'(0);
   localparam logic [POS_BITS-1:0] RIGHT_RESET  = POS_BITS'(79);
   localparam logic [POS_BITS-1:0] BOTTOM_RESET = POS_BITS'(24);

   // Request modes
   typedef enum logic [1:0] {
      MODE_BYTE  = 2'd0,
      MODE_SET   = 2'd1,
      MODE_CLEAR = 2'd2
   } mode_type;

   // Register indexes
   typedef enum logic [CSR_BITS-1:0] {
      CSR_LEFT   = 2'd0,
      CSR_TOP    = 2'd1,
      CSR_RIGHT  = 2'd2,
      CSR_BOTTOM = 2'd3
   } csr_index_type;

   // One result word
   typedef struct packed {
      logic [POS_BITS-1:0] pos_x;
      logic [POS_BITS-1:0] pos_y;
      logic [BTN_BITS-1:0] buttons;
      logic                left_press;
      logic                right_press;
      logic                middle_press;
      logic                moved;
      logic                packet_accepted;
      logic                packet_dropped;
   } rsp_type;

   // Clamp to lo first, then to hi, so hi wins on crossed bounds
   function automatic logic [POS_BITS-1:0] clamp_axis(
      input logic signed [SUM_BITS-1:0] v,
      input logic [POS_BITS-1:0]        lo,
      input logic [POS_BITS-1:0]        hi
   );
      logic signed [SUM_BITS-1:0] r;
      r = v;
      if (r < $signed({2'b00, lo})) r = $signed({2'b00, lo});
      if (r > $signed({2'b00, hi})) r = $signed({2'b00, hi});
      return r[POS_BITS-1:0];
   endfunction

   // Sign-extend a 9-bit motion value, zero it on overflow and divide by 8
   // truncating toward zero; the result is widened to SUM_BITS
   function automatic logic signed [SUM_BITS-1:0] scaled_move(
      input logic [7:0] low8,
      input logic       sign,
      input logic       ovf
   );
      logic signed [RAW_BITS-1:0]  d;
      logic signed [RAW_BITS-1:0]  s;
      logic signed [MOVE_BITS-1:0] q;
      d = $signed({sign, sign, low8});
      if (ovf) d = '0;
      if (d < 0) d = d + RAW_BITS'(7);
      s = d >>> MOVE_SHIFT;
      q = s[MOVE_BITS-1:0];
      return $signed({{(SUM_BITS-MOVE_BITS){q[MOVE_BITS-1]}}, q});
   endfunction

endpackage

### hw/rtl/ps2_mouse_packet_cursor_tracker.sv
// ============================================================================
// ps2_mouse_packet_cursor_tracker
// Gathers PS/2 mouse bytes into packets and keeps a bounded cursor, button
// state and sticky press and motion flags; also takes set and clear requests.
// ============================================================================
// Each accepted request word yields one registered response word.
// Throughput: one word per cycle while req_stall is low; the update is a
// single pass of logic between the state registers and the output register.
// A two-entry output buffer (output register plus skid) lets a request be
// taken while a response waits; req_stall rises only when both are full.
// Reset (synchronous): bounds 0/0/79/24, cursor, buttons, flags and byte
// count cleared, output buffer empty.
module ps2_mouse_packet_cursor_tracker (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_mode,
   input  logic [7:0]                         req_data_byte,
   input  logic [ps2mct_pkg::POS_BITS-1:0]    req_set_x,
   input  logic [ps2mct_pkg::POS_BITS-1:0]    req_set_y,

   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [ps2mct_pkg::POS_BITS-1:0]    rsp_pos_x,
   output logic [ps2mct_pkg::POS_BITS-1:0]    rsp_pos_y,
   output logic [ps2mct_pkg::BTN_BITS-1:0]    rsp_buttons,
   output logic                               rsp_left_press,
   output logic                               rsp_right_press,
   output logic                               rsp_middle_press,
   output logic                               rsp_moved,
   output logic                               rsp_packet_accepted,
   output logic                               rsp_packet_dropped,

   input  logic                               csr_write,
   input  logic [ps2mct_pkg::CSR_BITS-1:0]    csr_index,
   input  logic [ps2mct_pkg::POS_BITS-1:0]    csr_wdata
);

   // Bound registers
   logic [ps2mct_pkg::POS_BITS-1:0] left_ff, top_ff, right_ff, bottom_ff;

   // Tracker state
   logic [1:0]                      byte_count_ff, byte_count_in;
   logic [7:0]                      first_byte_ff, first_byte_in;
   logic [7:0]                      second_byte_ff, second_byte_in;
   logic [ps2mct_pkg::POS_BITS-1:0] cursor_x_ff, cursor_x_in;
   logic [ps2mct_pkg::POS_BITS-1:0] cursor_y_ff, cursor_y_in;
   logic [ps2mct_pkg::BTN_BITS-1:0] buttons_ff, buttons_in;
   logic [ps2mct_pkg::BTN_BITS-1:0] clicks_ff, clicks_in;
   logic                            moved_ff, moved_in;
   logic                            pkt_acc, pkt_drop;

   // Output buffer
   ps2mct_pkg::rsp_type             out_ff, out_in, skid_ff, skid_in, rsp_new;
   logic                            out_valid_ff, out_valid_in;
   logic                            skid_valid_ff, skid_valid_in;

   logic                            req_accept, rsp_take;
   logic signed [ps2mct_pkg::SUM_BITS-1:0] dx, dy, sum_x, sum_y;
   logic                            motion_nz;

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid & ~skid_valid_ff;
   assign rsp_take   = out_valid_ff & ~rsp_stall;

   // Scaled motion of a packet completed by the current byte
   always_comb begin
      dx = ps2mct_pkg::scaled_move(second_byte_ff, first_byte_ff[ps2mct_pkg::FLAG_X_SIGN],
                                   first_byte_ff[ps2mct_pkg::FLAG_X_OVF]);
      dy = ps2mct_pkg::scaled_move(req_data_byte, first_byte_ff[ps2mct_pkg::FLAG_Y_SIGN],
                                   first_byte_ff[ps2mct_pkg::FLAG_Y_OVF]);
      sum_x = $signed({2'b00, cursor_x_ff}) + dx;
      sum_y = $signed({2'b00, cursor_y_ff}) - dy;
      // raw motion is nonzero when not overflowed and sign or low bits set
      motion_nz =
         (~first_byte_ff[ps2mct_pkg::FLAG_X_OVF] &
          (first_byte_ff[ps2mct_pkg::FLAG_X_SIGN] | (|second_byte_ff))) |
         (~first_byte_ff[ps2mct_pkg::FLAG_Y_OVF] &
          (first_byte_ff[ps2mct_pkg::FLAG_Y_SIGN] | (|req_data_byte)));
   end

   // Next state for one request word
   always_comb begin
      byte_count_in  = byte_count_ff;
      first_byte_in  = first_byte_ff;
      second_byte_in = second_byte_ff;
      cursor_x_in    = cursor_x_ff;
      cursor_y_in    = cursor_y_ff;
      buttons_in     = buttons_ff;
      clicks_in      = clicks_ff;
      moved_in       = moved_ff;
      pkt_acc        = 1'b0;
      pkt_drop       = 1'b0;
      unique case (ps2mct_pkg::mode_type'(req_mode))
         ps2mct_pkg::MODE_BYTE: begin
            priority if (byte_count_ff == ps2mct_pkg::BYTE_FIRST) begin
               first_byte_in = req_data_byte;
               byte_count_in = ps2mct_pkg::BYTE_SECOND;
            end else if (byte_count_ff == ps2mct_pkg::BYTE_SECOND) begin
               second_byte_in = req_data_byte;
               byte_count_in  = ps2mct_pkg::BYTE_THIRD;
            end else begin
               byte_count_in = ps2mct_pkg::BYTE_FIRST;
               if (!first_byte_ff[ps2mct_pkg::FLAG_SYNC]) begin
                  pkt_drop = 1'b1;
               end else begin
                  pkt_acc     = 1'b1;
                  cursor_x_in = ps2mct_pkg::clamp_axis(sum_x, left_ff, right_ff);
                  cursor_y_in = ps2mct_pkg::clamp_axis(sum_y, top_ff, bottom_ff);
                  if (motion_nz) moved_in = 1'b1;
                  buttons_in = first_byte_ff[ps2mct_pkg::BTN_BITS-1:0];
                  clicks_in  = clicks_ff |
                               (first_byte_ff[ps2mct_pkg::BTN_BITS-1:0] & ~buttons_ff);
               end
            end
         end
         ps2mct_pkg::MODE_SET: begin
            cursor_x_in = ps2mct_pkg::clamp_axis($signed({2'b00, req_set_x}),
                                                 left_ff, right_ff);
            cursor_y_in = ps2mct_pkg::clamp_axis($signed({2'b00, req_set_y}),
                                                 top_ff, bottom_ff);
         end
         ps2mct_pkg::MODE_CLEAR: begin
            clicks_in = '0;
            moved_in  = 1'b0;
         end
         default: begin
            // unused mode: nothing changes
         end
      endcase
   end

   // Response word built from the next state
   always_comb begin
      rsp_new.pos_x           = cursor_x_in;
      rsp_new.pos_y           = cursor_y_in;
      rsp_new.buttons         = buttons_in;
      rsp_new.left_press      = clicks_in[0];
      rsp_new.right_press     = clicks_in[1];
      rsp_new.middle_press    = clicks_in[2];
      rsp_new.moved           = moved_in;
      rsp_new.packet_accepted = pkt_acc;
      rsp_new.packet_dropped  = pkt_drop;
   end

   // Output register and skid stage
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || rsp_take) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = rsp_new;
            out_valid_in = req_accept;
         end
      end else if (req_accept) begin
         skid_in       = rsp_new;
         skid_valid_in = 1'b1;
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff  <= ps2mct_pkg::BYTE_FIRST;
         first_byte_ff  <= '0;
         second_byte_ff <= '0;
         cursor_x_ff    <= '0;
         cursor_y_ff    <= '0;
         buttons_ff     <= '0;
         clicks_ff      <= '0;
         moved_ff       <= 1'b0;
         out_valid_ff   <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         if (req_accept) begin
            byte_count_ff  <= byte_count_in;
            first_byte_ff  <= first_byte_in;
            second_byte_ff <= second_byte_in;
            cursor_x_ff    <= cursor_x_in;
            cursor_y_ff    <= cursor_y_in;
            buttons_ff     <= buttons_in;
            clicks_ff      <= clicks_in;
            moved_ff       <= moved_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   // Bound registers
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= ps2mct_pkg::LEFT_RESET;
         top_ff    <= ps2mct_pkg::TOP_RESET;
         right_ff  <= ps2mct_pkg::RIGHT_RESET;
         bottom_ff <= ps2mct_pkg::BOTTOM_RESET;
      end else if (csr_write) begin
         unique case (ps2mct_pkg::csr_index_type'(csr_index))
            ps2mct_pkg::CSR_LEFT:   left_ff   <= csr_wdata;
            ps2mct_pkg::CSR_TOP:    top_ff    <= csr_wdata;
            ps2mct_pkg::CSR_RIGHT:  right_ff  <= csr_wdata;
            ps2mct_pkg::CSR_BOTTOM: bottom_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_pos_x           = out_ff.pos_x;
   assign rsp_pos_y           = out_ff.pos_y;
   assign rsp_buttons         = out_ff.buttons;
   assign rsp_left_press      = out_ff.left_press;
   assign rsp_right_press     = out_ff.right_press;
   assign rsp_middle_press    = out_ff.middle_press;
   assign rsp_moved           = out_ff.moved;
   assign rsp_packet_accepted = out_ff.packet_accepted;
   assign rsp_packet_dropped  = out_ff.packet_dropped;

   // Skid holds a word only behind a waiting output word
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word without output word");

   // Byte counter never reaches the unused code
   a_byte_count_range: assert property (@(posedge clock) disable iff (reset)
      byte_count_ff != 2'd3)
      else $error("byte count out of range");

   // A packet is either accepted or dropped, never both
   a_pkt_exclusive: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_ff.packet_accepted && out_ff.packet_dropped))
      else $error("packet both accepted and dropped");

   // Third byte of a packet returns the counter to the first position
   a_count_wraps: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_mode == ps2mct_pkg::MODE_BYTE &&
       byte_count_ff == ps2mct_pkg::BYTE_THIRD)
      |=> byte_count_ff == ps2mct_pkg::BYTE_FIRST)
      else $error("byte count did not wrap after third byte");

endmodule

### tb/tb_ps2_mouse_packet_cursor_tracker.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_ps2_mouse_packet_cursor_tracker
// Self-checking bench for the PS/2 mouse cursor tracker. A short table of
// directed words runs at the reset bounds. Random packets, noise bytes, set,
// clear and unused words follow under several bound settings and idle patterns.
// Every response word is checked field by field against a predictor of the
// cursor, button and flag state kept here, or against a typed row's word.
// ============================================================================
module tb_ps2_mouse_packet_cursor_tracker;
   import ps2mct_pkg::*;

   localparam int HALF_PERIOD     = 5;
   localparam int RESET_CYCLES    = 11;
   localparam int DIRECTED_COUNT  = 28;
   localparam int RANDOM_PHASES   = 8;
   localparam int WORDS_PER_PHASE = 200;
   localparam int PRESSURE_PHASE  = 4;
   localparam int LONG_HOLD       = 80;
   localparam int SETTLE_CYCLES   = 3;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int PRINT_LIMIT     = 40;
   localparam int IDLE_ONE_SIDE   = 61;
   localparam int IDLE_BOTH_SIDES = 28;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   localparam rsp_type IDLE_WORD   = '0;
   localparam rsp_type CORNER_WORD = {RIGHT_RESET, BOTTOM_RESET, 9'd0};

   typedef struct packed {
      logic [1:0]          mode;
      logic [7:0]          data;
      logic [POS_BITS-1:0] sx;
      logic [POS_BITS-1:0] sy;
      logic                typed;
      rsp_type             want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                req_valid     = 1'b0;
   logic                req_stall;
   logic [1:0]          req_mode      = '0;
   logic [7:0]          req_data_byte = '0;
   logic [POS_BITS-1:0] req_set_x     = '0;
   logic [POS_BITS-1:0] req_set_y     = '0;

   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [POS_BITS-1:0] rsp_pos_x;
   logic [POS_BITS-1:0] rsp_pos_y;
   logic [BTN_BITS-1:0] rsp_buttons;
   logic                rsp_left_press;
   logic                rsp_right_press;
   logic                rsp_middle_press;
   logic                rsp_moved;
   logic                rsp_packet_accepted;
   logic                rsp_packet_dropped;

   logic                csr_write = 1'b0;
   logic [CSR_BITS-1:0] csr_index = '0;
   logic [POS_BITS-1:0] csr_wdata = '0;

   // predicted tracker state
   logic [POS_BITS-1:0] bound_reg [4] = '{LEFT_RESET, TOP_RESET, RIGHT_RESET, BOTTOM_RESET};
   logic [1:0]          pkt_pos      = BYTE_FIRST;
   logic [7:0]          pkt_head     = '0;
   logic [7:0]          pkt_x_low    = '0;
   logic [POS_BITS-1:0] cur_x        = '0;
   logic [POS_BITS-1:0] cur_y        = '0;
   logic [BTN_BITS-1:0] btn_held     = '0;
   logic [BTN_BITS-1:0] click_sticky = '0;
   logic                moved_sticky = 1'b0;

   rsp_type      pending_cursor_words [$];
   stim_row_type directed_rows [DIRECTED_COUNT];

   int  error_count     = 0;
   int  phase_idx       = -1;
   int  phase_words     = 0;
   int  total_words     = 0;
   int  taken_packets   = 0;
   int  dropped_packets = 0;
   int  quiet_cycles    = 0;
   int  hold_left       = 0;
   int  idle_pct        = IDLE_ONE_SIDE;
   bit  pressure_done   = 1'b0;
   bit  sender_idles    = 1'b0;
   bit  receiver_stalls = 1'b0;

   ps2_mouse_packet_cursor_tracker dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_mode            (req_mode),
      .req_data_byte       (req_data_byte),
      .req_set_x           (req_set_x),
      .req_set_y           (req_set_y),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_pos_x           (rsp_pos_x),
      .rsp_pos_y           (rsp_pos_y),
      .rsp_buttons         (rsp_buttons),
      .rsp_left_press      (rsp_left_press),
      .rsp_right_press     (rsp_right_press),
      .rsp_middle_press    (rsp_middle_press),
      .rsp_moved           (rsp_moved),
      .rsp_packet_accepted (rsp_packet_accepted),
      .rsp_packet_dropped  (rsp_packet_dropped),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // 9-bit motion value, zeroed on overflow
   function automatic int raw_motion(logic [7:0] low8, logic sign, logic ovf);
      int r;
      r = int'(low8);
      if (sign) r = r - 256;
      if (ovf) r = 0;
      return r;
   endfunction

   // lower bound first, so the upper bound wins when they cross
   function automatic logic [POS_BITS-1:0] bound_axis(int v, logic [POS_BITS-1:0] lo,
                                                      logic [POS_BITS-1:0] hi);
      int r;
      r = v;
      if (r < int'(lo)) r = int'(lo);
      if (r > int'(hi)) r = int'(hi);
      return r[POS_BITS-1:0];
   endfunction

   // advance the tracker state by one request word, return its response word
   function automatic rsp_type predict_cursor_word(logic [1:0] m, logic [7:0] d,
                                                   logic [POS_BITS-1:0] sx,
                                                   logic [POS_BITS-1:0] sy);
      rsp_type             w;
      int                  dx;
      int                  dy;
      logic [BTN_BITS-1:0] prev;
      w = '0;
      if (m == MODE_BYTE) begin
         if (pkt_pos == BYTE_FIRST) begin
            pkt_head = d;
            pkt_pos  = BYTE_SECOND;
         end else if (pkt_pos == BYTE_SECOND) begin
            pkt_x_low = d;
            pkt_pos   = BYTE_THIRD;
         end else begin
            pkt_pos = BYTE_FIRST;
            if (!pkt_head[FLAG_SYNC]) begin
               w.packet_dropped = 1'b1;
               dropped_packets++;
            end else begin
               w.packet_accepted = 1'b1;
               taken_packets++;
               dx = raw_motion(pkt_x_low, pkt_head[FLAG_X_SIGN], pkt_head[FLAG_X_OVF]);
               dy = raw_motion(d, pkt_head[FLAG_Y_SIGN], pkt_head[FLAG_Y_OVF]);
               cur_x = bound_axis(int'(cur_x) + dx / 8, bound_reg[CSR_LEFT],
                                  bound_reg[CSR_RIGHT]);
               cur_y = bound_axis(int'(cur_y) - dy / 8, bound_reg[CSR_TOP],
                                  bound_reg[CSR_BOTTOM]);
               if (dx != 0 || dy != 0) moved_sticky = 1'b1;
               prev         = btn_held;
               btn_held     = pkt_head[BTN_BITS-1:0];
               click_sticky = click_sticky | (btn_held & ~prev);
            end
         end
      end else if (m == MODE_SET) begin
         cur_x = bound_axis(int'(sx), bound_reg[CSR_LEFT], bound_reg[CSR_RIGHT]);
         cur_y = bound_axis(int'(sy), bound_reg[CSR_TOP], bound_reg[CSR_BOTTOM]);
      end else if (m == MODE_CLEAR) begin
         click_sticky = '0;
         moved_sticky = 1'b0;
      end
      w.pos_x        = cur_x;
      w.pos_y        = cur_y;
      w.buttons      = btn_held;
      w.left_press   = click_sticky[0];
      w.right_press  = click_sticky[1];
      w.middle_press = click_sticky[2];
      w.moved        = moved_sticky;
      return w;
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= PRINT_LIMIT) $display("[%0t] MISMATCH %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s: got %0d expected %0d", name, got, want));
   endtask

   // offer one word at the falling edge, hold it until taken
   task automatic send_word(input logic [1:0] m, input logic [7:0] d,
                            input logic [POS_BITS-1:0] sx, input logic [POS_BITS-1:0] sy,
                            input logic use_typed, input rsp_type typed_word);
      rsp_type predicted;
      logic    taken;
      while (sender_idles && $urandom_range(99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid     = 1'b1;
      req_mode      = m;
      req_data_byte = d;
      req_set_x     = sx;
      req_set_y     = sy;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = !req_stall;
      end
      predicted = predict_cursor_word(m, d, sx, sy);
      pending_cursor_words.push_back(use_typed ? typed_word : predicted);
      if (m != MODE_UNUSED) begin
         phase_words++;
         total_words++;
      end
      @(negedge clock);
   endtask

   function automatic logic [POS_BITS-1:0] pick_coord();
      int p;
      p = $urandom_range(9);
      if (p == 0) return '0;
      if (p == 1) return '1;
      return POS_BITS'($urandom_range(4095));
   endfunction

   function automatic logic [7:0] motion_byte();
      if ($urandom_range(9) == 0) return 8'h00;
      return 8'($urandom_range(255));
   endfunction

   // mostly whole packets; noise bytes, set, clear and unused words mixed in
   task automatic send_random_item();
      int         pick;
      logic [7:0] head;
      pick = $urandom_range(99);
      if (pick < 70) begin
         // finish whatever partial packet the noise left behind
         while (pkt_pos != BYTE_FIRST)
            send_word(MODE_BYTE, 8'($urandom_range(255)), pick_coord(), pick_coord(),
                      1'b0, IDLE_WORD);
         head            = 8'($urandom_range(255));
         head[FLAG_SYNC]  = ($urandom_range(99) < 85);
         head[FLAG_X_OVF] = ($urandom_range(99) < 12);
         head[FLAG_Y_OVF] = ($urandom_range(99) < 12);
         send_word(MODE_BYTE, head, pick_coord(), pick_coord(), 1'b0, IDLE_WORD);
         if ($urandom_range(99) < 8)
            send_word($urandom_range(1) ? MODE_SET : MODE_CLEAR, 8'($urandom_range(255)),
                      pick_coord(), pick_coord(), 1'b0, IDLE_WORD);
         send_word(MODE_BYTE, motion_byte(), pick_coord(), pick_coord(), 1'b0, IDLE_WORD);
         send_word(MODE_BYTE, motion_byte(), pick_coord(), pick_coord(), 1'b0, IDLE_WORD);
      end else if (pick < 80) begin
         send_word(MODE_BYTE, 8'($urandom_range(255)), pick_coord(), pick_coord(),
                   1'b0, IDLE_WORD);
      end else if (pick < 88) begin
         send_word(MODE_SET, 8'($urandom_range(255)), pick_coord(), pick_coord(),
                   1'b0, IDLE_WORD);
      end else if (pick < 95) begin
         send_word(MODE_CLEAR, 8'($urandom_range(255)), pick_coord(), pick_coord(),
                   1'b0, IDLE_WORD);
      end else begin
         send_word(MODE_UNUSED, 8'($urandom_range(255)), pick_coord(), pick_coord(),
                   1'b0, IDLE_WORD);
      end
   endtask

   task automatic write_bound(input csr_index_type idx, input logic [POS_BITS-1:0] val);
      csr_write = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_write = 1'b0;
      bound_reg[idx] = val;
   endtask

   task automatic wait_drained();
      while (pending_cursor_words.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // response side: random stalls, plus one long hold in the pressure phase
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left--;
      end else if (phase_idx == PRESSURE_PHASE && !pressure_done && phase_words > 20) begin
         pressure_done = 1'b1;
         hold_left     = LONG_HOLD - 1;
         rsp_stall     = 1'b1;
      end else begin
         rsp_stall = receiver_stalls && ($urandom_range(99) < idle_pct);
      end
   end

   // compare each taken response word with the oldest prediction
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_pos_x, rsp_pos_y, rsp_buttons, rsp_left_press, rsp_right_press,
                rsp_middle_press, rsp_moved, rsp_packet_accepted, rsp_packet_dropped};
         if (pending_cursor_words.size() == 0) begin
            report_mismatch("response word with nothing pending");
         end else begin
            want = pending_cursor_words.pop_front();
            check_field("pos_x", 16'(got.pos_x), 16'(want.pos_x));
            check_field("pos_y", 16'(got.pos_y), 16'(want.pos_y));
            check_field("buttons", 16'(got.buttons), 16'(want.buttons));
            check_field("left_press", 16'(got.left_press), 16'(want.left_press));
            check_field("right_press", 16'(got.right_press), 16'(want.right_press));
            check_field("middle_press", 16'(got.middle_press), 16'(want.middle_press));
            check_field("moved", 16'(got.moved), 16'(want.moved));
            check_field("packet_accepted", 16'(got.packet_accepted),
                        16'(want.packet_accepted));
            check_field("packet_dropped", 16'(got.packet_dropped),
                        16'(want.packet_dropped));
         end
      end
   end

   // watchdog: too long without any word moving on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired after %0d quiet cycles", quiet_cycles);
         $display("ps2_mouse_packet_cursor_tracker regression: fail");
         $finish;
      end
   end

   initial begin
      logic [POS_BITS-1:0] nb [4];
      int                  lo;

      directed_rows = '{
         // clear and unused mode straight after reset
         '{MODE_CLEAR,  8'h00, 12'h000, 12'h000, 1'b1, IDLE_WORD},
         '{MODE_UNUSED, 8'hFF, 12'hFFF, 12'hFFF, 1'b1, IDLE_WORD},
         // set at both extremes, clamped to the reset bounds
         '{MODE_SET,    8'h00, 12'hFFF, 12'hFFF, 1'b1, CORNER_WORD},
         '{MODE_SET,    8'hFF, 12'h000, 12'h000, 1'b1, IDLE_WORD},
         // left press, positive X step of 127
         '{MODE_BYTE,   8'h09, 12'h000, 12'h000, 1'b0, IDLE_WORD},
         '{MODE_BYTE,   8'h7F, 12'h000, 12'h000, 1'b0, IDLE_WORD},
         '{MODE_BYTE,   8'h00, 12'h000, 12'h000, 1'b0, IDLE_WORD},
         // sign bit with a zero byte is -256 on both axes
         '{MODE_BYTE,   8'h38, 12'h000, 12'h000, 1'b0, IDLE_WORD},
         '{MODE_BYTE,   8'h00, 12'h000, 12'h000, 1'b0, IDLE_WORD},
         '{MODE_BYTE,   8'h00, 12'h000, 12'h000, 1'b0, IDLE_WORD},
         // sync bit clear: packet dropped
         '{MODE_BYTE,   8'h07, 12'h000, 12'h000, 1'b0, IDLE_WORD},
         '{MODE_BYTE,   8'h10, 12'h000, 12'h000, 1'b0, IDLE_WORD},
         '{MODE_BYTE,   8'h10, 12'h000, 12'h000, 1'b0, IDLE_WORD},
         // set and clear in the middle of a packet
         '{MODE_BYTE,   8'h0A, 12'h000, 12'h000, 1'b0, IDLE_WORD},
         '{MODE_SET,    8'h00, 12'h028, 12'h00C, 1'b0, IDLE_WORD},
         '{MODE_CLEAR,  8'h00, 12'h000, 12'h000, 1'b0, IDLE_WORD},
         '{MODE_BYTE,   8'h80, 12'h000, 12'h000, 1'b0, IDLE_WORD},
         '{MODE_BYTE,   8'h01, 12'h000, 12'h000, 1'b0, IDLE_WORD},
         // all buttons, positive X step of 248
         '{MODE_BYTE,   8'h0F, 12'h000, 12'h000, 1'b0, IDLE_WORD},
         '{MODE_BYTE,   8'hF8, 12'h000, 12'h000, 1'b0, IDLE_WORD},
         '{MODE_BYTE,   8'h08, 12'h000, 12'h000, 1'b0, IDLE_WORD},
         // every flag set, both overflows
         '{MODE_BYTE,   8'hFF, 12'hFFF, 12'hFFF, 1'b0, IDLE_WORD},
         '{MODE_BYTE,   8'hFF, 12'hFFF, 12'hFFF, 1'b0, IDLE_WORD},
         '{MODE_BYTE,   8'hFF, 12'hFFF, 12'hFFF, 1'b0, IDLE_WORD},
         // raw motion below one step still sets moved; Y drives past the top
         '{MODE_BYTE,   8'h08, 12'h000, 12'h000, 1'b0, IDLE_WORD},
         '{MODE_BYTE,   8'h01, 12'h000, 12'h000, 1'b0, IDLE_WORD},
         '{MODE_BYTE,   8'hFF, 12'h000, 12'h000, 1'b0, IDLE_WORD},
         '{MODE_CLEAR,  8'h00, 12'h000, 12'h000, 1'b0, IDLE_WORD}
      };

      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;

      // directed table at the reset bounds, no idling
      phase_idx = 0;
      for (int i = 0; i < DIRECTED_COUNT; i++)
         send_word(directed_rows[i].mode, directed_rows[i].data, directed_rows[i].sx,
                   directed_rows[i].sy, directed_rows[i].typed, directed_rows[i].want);
      req_valid = 1'b0;
      wait_drained();

      // random phases, each with its own bounds and idle pattern
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: nb = '{12'd0, 12'd0, 12'hFFF, 12'hFFF};
            1: nb = '{12'd100, 12'd50, 12'd200, 12'd150};
            2: nb = '{12'd300, 12'd300, 12'd100, 12'd100};
            3: nb = '{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF};
            4: nb = '{12'd0, 12'd0, 12'd0, 12'd0};
            7: for (int i = 0; i < 4; i++) nb[i] = POS_BITS'($urandom_range(4095));
            default: begin
               lo    = $urandom_range(3000);
               nb[0] = POS_BITS'(lo);
               nb[2] = POS_BITS'(lo + $urandom_range(1095));
               lo    = $urandom_range(3000);
               nb[1] = POS_BITS'(lo);
               nb[3] = POS_BITS'(lo + $urandom_range(1095));
            end
         endcase
         for (int i = 0; i < 4; i++) write_bound(csr_index_type'(i), nb[i]);

         sender_idles    = (p % 4 == 1) || (p % 4 == 3);
         receiver_stalls = (p % 4 == 2) || (p % 4 == 3);
         // lighter idling when both sides hold off
         idle_pct        = (p % 4 == 3) ? IDLE_BOTH_SIDES : IDLE_ONE_SIDE;
         phase_words     = 0;
         phase_idx       = p + 1 == PRESSURE_PHASE ? PRESSURE_PHASE : p + 1;
         if (p == PRESSURE_PHASE) phase_idx = PRESSURE_PHASE;
         while (phase_words < WORDS_PER_PHASE) send_random_item();
         req_valid = 1'b0;
         phase_idx = -1;
         wait_drained();
      end

      if (pending_cursor_words.size() != 0)
         report_mismatch($sformatf("%0d response words never arrived",
                                   pending_cursor_words.size()));

      $display("covered %0d request words over %0d bound settings, %0d directed",
               total_words, RANDOM_PHASES + 1, DIRECTED_COUNT);
      $display("packets taken %0d, dropped %0d; output held off %0d cycles once",
               taken_packets, dropped_packets, LONG_HOLD);
      if (error_count == 0)
         $display("ps2_mouse_packet_cursor_tracker regression: pass");
      else
         $display("ps2_mouse_packet_cursor_tracker regression: fail");
      $finish;
   end

endmodule
